FILE: hw/rtl/tpc_pkg.sv
// Shared types and constants of the tilt posture classifier.
package tpc_pkg;

  // Configuration register indexes
  localparam logic CFG_OFF_MARKER = 1'b0;
  localparam logic CFG_PRES_THR   = 1'b1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SAMPLE_W   = 16;

  // Register reset values
  localparam logic signed [SAMPLE_W-1:0] OFF_MARKER_RST = 16'sh8000;
  localparam logic [CFG_DATA_W-1:0]      PRES_THR_RST   = 16'd256;

  // Tangent constants, unsigned Q16: tan(0.5) and tan(pi - 2.5)
  localparam logic [15:0] TAN_FRONT = 16'd35802;
  localparam logic [15:0] TAN_BACK  = 16'd48957;

  // Posture codes on the output word
  typedef enum logic [2:0] {
    POSTURE_UPRIGHT = 3'd0,
    POSTURE_FRONT   = 3'd1,
    POSTURE_BACK    = 3'd2,
    POSTURE_LEFT    = 3'd3,
    POSTURE_RIGHT   = 3'd4
  } posture_e;

  // Result of one angle test
  typedef enum logic [1:0] {
    TILT_NONE  = 2'd0,
    TILT_SMALL = 2'd1,
    TILT_LARGE = 2'd2
  } tilt_e;

  // Pipeline advance strobes
  typedef struct packed {
    logic accept;
    logic en2;
    logic en3;
    logic en_out;
  } tpc_pipe_t;

endpackage

FILE: hw/rtl/tpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpc_ram #(
  parameter int unsigned WIDTH  = 48,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tpc_axis_lane.sv
// One axis lane: running sum, distance from the off marker, magnitude and sign.
module tpc_axis_lane
  import tpc_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned SUM_W = 16 + $clog2(DEPTH),
  parameter int unsigned CNT_W = $clog2(DEPTH + 1),
  parameter int unsigned DIFF_W = SUM_W + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tpc_pipe_t                  ctrl_i,
  input  logic                       full_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [SAMPLE_W-1:0] old_i,
  input  logic [CNT_W-1:0]           n_i,
  input  logic signed [SAMPLE_W-1:0] off_marker_i,
  output logic [DIFF_W-1:0]          dist_o,
  output logic [SUM_W-1:0]           mag_o,
  output logic                       pos_o,
  output logic                       neg_o
);

  localparam int unsigned NM_W = CNT_W + SAMPLE_W + 1;

  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [SUM_W-1:0]  s1_q;
  logic signed [NM_W-1:0]   nm;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        dist_q, dist_d;
  logic [SUM_W-1:0]         mag_q, mag_d;
  logic                     pos_q, neg_q;

  // Running sum: drop the oldest sample once the window is full
  always_comb begin
    sum_d = sum_q + SUM_W'(sample_i);
    if (full_i) begin
      sum_d = sum_d - SUM_W'(old_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.accept) begin
      sum_q <= sum_d;
    end
  end

  // Stage 1: snapshot of the updated sum
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      s1_q <= sum_d;
    end
  end

  // Stage 2: |S - n*off|, |S| and sign flags
  always_comb begin
    nm     = $signed({1'b0, n_i}) * off_marker_i;
    diff   = $signed({s1_q[SUM_W-1], s1_q}) - $signed(nm[DIFF_W-1:0]);
    dist_d = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    mag_d  = s1_q[SUM_W-1] ? SUM_W'(-s1_q) : SUM_W'(s1_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en2) begin
      dist_q <= dist_d;
      mag_q  <= mag_d;
      neg_q  <= s1_q[SUM_W-1];
      pos_q  <= !s1_q[SUM_W-1] && (s1_q != '0);
    end
  end

  assign dist_o = dist_q;
  assign mag_o  = mag_q;
  assign pos_o  = pos_q;
  assign neg_o  = neg_q;

endmodule

FILE: hw/rtl/tpc_merge.sv
// Merge stage: presence test across the lanes and the two angle tests.
module tpc_merge
  import tpc_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned SUM_W = 16 + $clog2(DEPTH),
  parameter int unsigned CNT_W = $clog2(DEPTH + 1),
  parameter int unsigned DIFF_W = SUM_W + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tpc_pipe_t             ctrl_i,
  input  logic [CNT_W-1:0]      n_i,
  input  logic [CFG_DATA_W-1:0] threshold_i,
  input  logic [DIFF_W-1:0]     dist_x_i,
  input  logic [DIFF_W-1:0]     dist_y_i,
  input  logic [DIFF_W-1:0]     dist_z_i,
  input  logic [SUM_W-1:0]      mag_x_i,
  input  logic [SUM_W-1:0]      mag_y_i,
  input  logic [SUM_W-1:0]      mag_z_i,
  input  logic                  pos_x_i,
  input  logic                  neg_x_i,
  input  logic                  pos_y_i,
  input  logic                  neg_y_i,
  output posture_e              posture_o,
  output logic                  present_o
);

  localparam int unsigned PROD_W = SUM_W + 16;
  localparam int unsigned DIST_W = DIFF_W + 2;
  localparam int unsigned THR_W  = CFG_DATA_W + CNT_W;
  localparam int unsigned CMP_W  = (DIST_W > THR_W) ? DIST_W : THR_W;

  logic [PROD_W-1:0] px_q, py_q;
  logic [SUM_W-1:0]  magz_q;
  logic              posx_q, negx_q, posy_q, negy_q;
  logic [DIST_W-1:0] dist_q;
  logic [THR_W-1:0]  thr_n_q;
  logic [15:0]       tan_x, tan_y;
  logic [PROD_W-1:0] az;
  tilt_e             cls_x, cls_y;
  posture_e          posture_q, posture_d;
  logic              present_q, present_d;

  // Angle test on one pair of sums, as multiply-compare
  function automatic tilt_e tilt_class(logic pos, logic neg, logic [PROD_W-1:0] p,
                                       logic [PROD_W-1:0] a, logic z_zero);
    tilt_e r;
    r = TILT_NONE;
    if (!pos && !neg && z_zero) begin
      r = TILT_SMALL;
    end else if (pos && (a < p)) begin
      r = TILT_SMALL;
    end else if (neg && (a < p)) begin
      r = TILT_LARGE;
    end
    return r;
  endfunction

  // Stage 3: tangent products, distance total and scaled threshold
  assign tan_x = pos_x_i ? TAN_FRONT : TAN_BACK;
  assign tan_y = pos_y_i ? TAN_FRONT : TAN_BACK;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en3) begin
      px_q    <= tan_x * mag_x_i;
      py_q    <= tan_y * mag_y_i;
      magz_q  <= mag_z_i;
      posx_q  <= pos_x_i;
      negx_q  <= neg_x_i;
      posy_q  <= pos_y_i;
      negy_q  <= neg_y_i;
      dist_q  <= DIST_W'(dist_x_i) + DIST_W'(dist_y_i) + DIST_W'(dist_z_i);
      thr_n_q <= threshold_i * n_i;
    end
  end

  // Stage 4: compares and posture pick
  always_comb begin
    az        = {magz_q, 16'h0000};
    cls_x     = tilt_class(posx_q, negx_q, px_q, az, magz_q == '0);
    cls_y     = tilt_class(posy_q, negy_q, py_q, az, magz_q == '0);
    present_d = CMP_W'(dist_q) > CMP_W'(thr_n_q);
    posture_d = POSTURE_UPRIGHT;
    if (present_d) begin
      case (cls_x)
        TILT_SMALL: posture_d = POSTURE_FRONT;
        TILT_LARGE: posture_d = POSTURE_BACK;
        default: begin
          case (cls_y)
            TILT_SMALL: posture_d = POSTURE_LEFT;
            TILT_LARGE: posture_d = POSTURE_RIGHT;
            default:    posture_d = POSTURE_UPRIGHT;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      posture_q <= POSTURE_UPRIGHT;
      present_q <= 1'b0;
    end else if (ctrl_i.en_out) begin
      posture_q <= posture_d;
      present_q <= present_d;
    end
  end

  assign posture_o = posture_q;
  assign present_o = present_q;

endmodule

FILE: hw/rtl/tilt_posture_classifier_unit.sv
// Top level of the tilt posture classifier: stream ports, window RAM and pipeline control.

// Takes one three-axis sample word per cycle while the output does not stall and returns
// one result word per sample through the stage 1, 2, 3 and output registers. The block
// keeps a window of the last DEPTH samples in one RAM (all three axes side by side, one
// read and one write port) and a running sum per axis; three axis lanes work in parallel
// and a merge stage does the presence test and the front/back then left/right angle tests
// as multiply-compares on the sums. The pipeline sustains one word per cycle; a stall on
// the output only holds the stages that are full, so empty stages keep taking words. The
// RAM needs no clearing: a read entry is used only once the window is full. Registers must
// be written through the cfg port while no word is in flight; not enforced by the block.
module tilt_posture_classifier_unit
  import tpc_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,  // acc_x[15:0], acc_y[31:16], acc_z[47:32]
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,  // posture[2:0], sensor_present[3], zero[7:4]
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned SUM_W  = 16 + $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DIFF_W = SUM_W + 1;
  localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned HIST_W = 3 * SAMPLE_W;

  logic signed [SAMPLE_W-1:0] off_marker_q;
  logic [CFG_DATA_W-1:0]      threshold_q;

  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              full;
  logic [CNT_W-1:0]  n1_q, n2_q;

  logic v1_q, v2_q, v3_q, vout_q;
  logic ena1;
  tpc_pipe_t ctrl;

  logic [HIST_W-1:0] ram_rdata, old_word;
  logic [HIST_W-1:0] fwd_data_q;
  logic              fwd_q;

  logic [DIFF_W-1:0] dist_x, dist_y, dist_z;
  logic [SUM_W-1:0]  mag_x, mag_y, mag_z;
  logic              pos_x, neg_x, pos_y, neg_y, pos_z, neg_z;
  posture_e          posture;
  logic              present;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_marker_q <= OFF_MARKER_RST;
      threshold_q  <= PRES_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OFF_MARKER: off_marker_q <= $signed(cfg_wdata_i);
        CFG_PRES_THR:   threshold_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline advance: a stage moves when it is empty or its successor moves
  assign ctrl.en_out = !vout_q || m_axis_tready;
  assign ctrl.en3    = !v3_q || ctrl.en_out;
  assign ctrl.en2    = !v2_q || ctrl.en3;
  assign ena1        = !v1_q || ctrl.en2;
  assign ctrl.accept = s_axis_tvalid && ena1;
  assign s_axis_tready = ena1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (ena1)        v1_q   <= ctrl.accept;
      if (ctrl.en2)    v2_q   <= v1_q;
      if (ctrl.en3)    v3_q   <= v2_q;
      if (ctrl.en_out) vout_q <= v3_q;
    end
  end

  // Window bookkeeping: fill count and ring slot
  assign full = (fill_q == CNT_W'(DEPTH));

  always_comb begin
    fill_d = fill_q;
    slot_d = slot_q;
    if (ctrl.accept) begin
      if (!full) begin
        fill_d = fill_q + 1'b1;
      end
      slot_d = (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      slot_q <= '0;
    end else begin
      fill_q <= fill_d;
      slot_q <= slot_d;
    end
  end

  // Count after the current sample, carried along the pipeline
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) n1_q <= fill_d;
    if (ctrl.en2)    n2_q <= n1_q;
  end

  // Window RAM, read one slot ahead so the oldest sample is ready on accept
  tpc_ram #(
    .WIDTH (HIST_W),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.accept),
    .waddr_i (slot_q),
    .wdata_i (s_axis_tdata),
    .raddr_i (slot_d),
    .rdata_o (ram_rdata)
  );

  // Forward a word written to the slot being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= ctrl.accept && (slot_d == slot_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      fwd_data_q <= s_axis_tdata;
    end
  end

  assign old_word = fwd_q ? fwd_data_q : ram_rdata;

  // Axis lanes
  tpc_axis_lane #(.DEPTH(DEPTH), .SUM_W(SUM_W), .CNT_W(CNT_W), .DIFF_W(DIFF_W)) u_lane_x (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .full_i       (full),
    .sample_i     ($signed(s_axis_tdata[15:0])),
    .old_i        ($signed(old_word[15:0])),
    .n_i          (n1_q),
    .off_marker_i (off_marker_q),
    .dist_o       (dist_x),
    .mag_o        (mag_x),
    .pos_o        (pos_x),
    .neg_o        (neg_x)
  );

  tpc_axis_lane #(.DEPTH(DEPTH), .SUM_W(SUM_W), .CNT_W(CNT_W), .DIFF_W(DIFF_W)) u_lane_y (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .full_i       (full),
    .sample_i     ($signed(s_axis_tdata[31:16])),
    .old_i        ($signed(old_word[31:16])),
    .n_i          (n1_q),
    .off_marker_i (off_marker_q),
    .dist_o       (dist_y),
    .mag_o        (mag_y),
    .pos_o        (pos_y),
    .neg_o        (neg_y)
  );

  tpc_axis_lane #(.DEPTH(DEPTH), .SUM_W(SUM_W), .CNT_W(CNT_W), .DIFF_W(DIFF_W)) u_lane_z (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .full_i       (full),
    .sample_i     ($signed(s_axis_tdata[47:32])),
    .old_i        ($signed(old_word[47:32])),
    .n_i          (n1_q),
    .off_marker_i (off_marker_q),
    .dist_o       (dist_z),
    .mag_o        (mag_z),
    .pos_o        (pos_z),
    .neg_o        (neg_z)
  );

  // Merge of the lane results
  tpc_merge #(.DEPTH(DEPTH), .SUM_W(SUM_W), .CNT_W(CNT_W), .DIFF_W(DIFF_W)) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .n_i         (n2_q),
    .threshold_i (threshold_q),
    .dist_x_i    (dist_x),
    .dist_y_i    (dist_y),
    .dist_z_i    (dist_z),
    .mag_x_i     (mag_x),
    .mag_y_i     (mag_y),
    .mag_z_i     (mag_z),
    .pos_x_i     (pos_x),
    .neg_x_i     (neg_x),
    .pos_y_i     (pos_y),
    .neg_y_i     (neg_y),
    .posture_o   (posture),
    .present_o   (present)
  );

  // z sign is folded into its magnitude; only the zero test is used
  logic z_sign_unused;
  assign z_sign_unused = pos_z ^ neg_z;

  // Output word
  assign m_axis_tvalid = vout_q;
  assign m_axis_tdata  = {3'b000, z_sign_unused & 1'b0, present, posture};

endmodule

FILE: dv/tb.sv
// Self-checking testbench of the tilt posture classifier: stimulus, result checker and stream drivers.
module tb
  import tpc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned STALL_LIMIT = 2000;

  // Mirror of the classifier: window, sums, registers and the queue of expected words
  class posture_scoreboard;
    typedef struct {
      posture_e posture;
      logic     present;
    } verdict_t;

    logic signed [15:0] win_x [DEPTH];
    logic signed [15:0] win_y [DEPTH];
    logic signed [15:0] win_z [DEPTH];
    longint             sum_x, sum_y, sum_z;
    int unsigned        filled, slot;
    longint             off_code, thr;
    verdict_t           verdict_q[$];
    int unsigned        errors;

    function new();
      foreach (win_x[i]) begin
        win_x[i] = '0;
        win_y[i] = '0;
        win_z[i] = '0;
      end
      sum_x    = 0;
      sum_y    = 0;
      sum_z    = 0;
      filled   = 0;
      slot     = 0;
      off_code = longint'(OFF_MARKER_RST);
      thr      = longint'(PRES_THR_RST);
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_OFF_MARKER: off_code = longint'($signed(value));
        CFG_PRES_THR:   thr      = longint'(value);
        default: ;
      endcase
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Angle test on one pair of sums, as a multiply-compare against the Q16 tangents
    function tilt_e tilt_of(longint s, longint sz);
      longint mag;
      mag = magnitude(sz) * 65536;
      if (s == 0 && sz == 0) return TILT_SMALL;
      if (s > 0 && mag < longint'(TAN_FRONT) * s) return TILT_SMALL;
      if (s < 0 && mag < longint'(TAN_BACK) * (-s)) return TILT_LARGE;
      return TILT_NONE;
    endfunction

    function void note_sample(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
      longint   n, dist_sum;
      verdict_t v;
      tilt_e    t;
      // full window: oldest sample leaves the sums before its slot is reused
      if (filled >= DEPTH) begin
        sum_x -= longint'(win_x[slot]);
        sum_y -= longint'(win_y[slot]);
        sum_z -= longint'(win_z[slot]);
      end else begin
        filled++;
      end
      win_x[slot] = x;
      win_y[slot] = y;
      win_z[slot] = z;
      sum_x += longint'(x);
      sum_y += longint'(y);
      sum_z += longint'(z);
      slot = (slot + 1) % DEPTH;

      n        = longint'(filled);
      dist_sum = magnitude(sum_x - n * off_code) + magnitude(sum_y - n * off_code)
               + magnitude(sum_z - n * off_code);
      v.posture = POSTURE_UPRIGHT;
      v.present = 1'b0;
      if (dist_sum > thr * n) begin
        v.present = 1'b1;
        t = tilt_of(sum_x, sum_z);
        if (t == TILT_SMALL) v.posture = POSTURE_FRONT;
        else if (t == TILT_LARGE) v.posture = POSTURE_BACK;
        else begin
          t = tilt_of(sum_y, sum_z);
          if (t == TILT_SMALL) v.posture = POSTURE_LEFT;
          else if (t == TILT_LARGE) v.posture = POSTURE_RIGHT;
        end
      end
      verdict_q.push_back(v);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] word);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing expected", word));
        return;
      end
      v = verdict_q.pop_front();
      if (word[2:0] !== v.posture)
        report_mismatch($sformatf("posture %0d, expected %0d", word[2:0], v.posture));
      if (word[3] !== v.present)
        report_mismatch($sformatf("sensor_present %b, expected %b", word[3], v.present));
      if (word[7:4] !== 4'b0)
        report_mismatch($sformatf("padding bits %b not zero", word[7:4]));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata;  // acc_x[15:0], acc_y[31:16], acc_z[47:32]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;  // posture[2:0], sensor_present[3], zero[7:4]
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  posture_scoreboard sb = new();
  bit                idling_on;
  bit                gaps_on;
  int unsigned       stall_left;
  int unsigned       samples_sent;

  tilt_posture_classifier_unit #(.DEPTH(DEPTH)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: random stall bursts while idling is on
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(1, 11) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Watchdog: ends the run after too many cycles without any word moving
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic int jitter(int amp);
    return int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  // Offer one sample word, optionally after a gap; returns at the falling edge after acceptance
  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(x, y, z);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // One register write; the write enable is low again when the task returns
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Wait until every expected word is back and the pipeline has emptied
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.verdict_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // One run of related samples: steady posture, absent sensor, tangent boundary or noise
  task automatic send_run();
    int                 kind, len, target, g, amp, zs, ax, b, sel;
    logic signed [15:0] x, y, z;
    kind    = $urandom_range(0, 9);
    gaps_on = idling_on && ($urandom_range(0, 3) != 0);
    len     = $urandom_range(1, 24);
    if (kind <= 5) begin
      target = $urandom_range(0, 4);
      g      = $urandom_range(64, 12000);
      amp    = g / 8 + 1;
      zs     = $urandom_range(0, 1) ? 1 : -1;
      repeat (len) begin
        case (target)
          0: begin
            x = 16'(jitter(amp));
            y = 16'(jitter(amp));
            z = 16'(zs * g + jitter(amp));
          end
          1: begin
            x = 16'(g + jitter(amp));
            y = 16'(jitter(amp));
            z = 16'(jitter(amp));
          end
          2: begin
            x = 16'(-g + jitter(amp));
            y = 16'(jitter(amp));
            z = 16'(jitter(amp));
          end
          3: begin
            x = 16'(jitter(amp / 4));
            y = 16'(g + jitter(amp));
            z = 16'(zs * (g / 3 + jitter(amp)));
          end
          default: begin
            x = 16'(jitter(amp / 4));
            y = 16'(-g + jitter(amp));
            z = 16'(zs * (g / 3 + jitter(amp)));
          end
        endcase
        send_sample(x, y, z);
      end
    end else if (kind == 6) begin
      // missing sensor: off marker on every axis, now and then a tiny deviation
      len = $urandom_range(12, 30);
      repeat (len) begin
        x = 16'(sb.off_code + (($urandom_range(0, 3) == 0) ? jitter(3) : 0));
        y = 16'(sb.off_code + (($urandom_range(0, 3) == 0) ? jitter(3) : 0));
        z = 16'(sb.off_code + (($urandom_range(0, 3) == 0) ? jitter(3) : 0));
        send_sample(x, y, z);
      end
    end else if (kind <= 8) begin
      // z right at a tangent boundary of the XZ or the YZ test
      sel = $urandom_range(0, 3);
      ax  = $urandom_range(1, 32767);
      b   = ((sel[0] ? int'(TAN_BACK) : int'(TAN_FRONT)) * ax) / 65536 + jitter(1);
      z   = 16'(($urandom_range(0, 1) ? 1 : -1) * b);
      if (sel[1]) begin
        x = '0;
        y = 16'(sel[0] ? -ax : ax);
      end else begin
        x = 16'(sel[0] ? -ax : ax);
        y = 16'($urandom);
      end
      repeat (len) send_sample(x, y, z);
    end else begin
      repeat (len) send_sample(16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_OFF_MARKER;
    cfg_wdata_i   = '0;
    idling_on     = 1'b1;
    gaps_on       = 1'b0;
    stall_left    = 0;
    samples_sent  = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part with reset register values
    gaps_on = 1'b1;
    send_sample(16'sd0, 16'sd0, 16'sd0);          // all sums zero: front
    send_sample(16'sd0, 16'sd0, 16'sd500);        // zero x sum, nonzero z: upright
    send_sample(-16'sd3000, 16'sd0, 16'sd0);      // negative x sum: back
    send_sample(16'sd3000, 16'sd2500, -16'sd500); // x and z sums back to zero
    send_sample(16'sd0, 16'sd0, 16'sd1000);       // left
    send_sample(16'sd0, -16'sd5000, 16'sd0);      // right
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(16'shffff, 16'sh0001, 16'shffff);
    send_sample(16'sh5555, 16'shaaaa, 16'sh5555);
    send_sample(16'shaaaa, 16'sh5555, 16'shaaaa);
    repeat (6) send_sample(16'sd2511, 16'sd30, -16'sd40); // fills past the window depth
    repeat (4) send_sample(16'sd20, -16'sd2511, 16'sd900);
    while (samples_sent < 100) send_run();
    drain();

    // Both extremes of presence: no margin at all, then the widest one
    write_cfg(CFG_OFF_MARKER, 16'h0000);
    write_cfg(CFG_PRES_THR, 16'h0000);
    while (samples_sent < 200) send_run();
    drain();

    write_cfg(CFG_OFF_MARKER, 16'h7fff);
    write_cfg(CFG_PRES_THR, 16'hffff);
    while (samples_sent < 300) send_run();
    drain();

    write_cfg(CFG_OFF_MARKER, 16'h8000);
    write_cfg(CFG_PRES_THR, 16'($urandom_range(0, 2000)));
    while (samples_sent < 400) send_run();
    drain();

    // Last part at full rate on both sides
    idling_on = 1'b0;
    write_cfg(CFG_PRES_THR, 16'($urandom_range(0, 4000)));
    write_cfg(CFG_OFF_MARKER, 16'($urandom));
    while (samples_sent < 500) send_run();
    drain();

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
